/* src/ttp_pkg.sv */
// ----------------------------------------------------------------------------
// ttp_pkg: shared types and constants of the text-to-panel pixel stream
// Font ROM, panel geometry, command codes and the job record that passes
// from the character front end to the beat sequencer.
// ----------------------------------------------------------------------------
package ttp_pkg;

    localparam int PANEL_WIDTH  = 128;
    localparam int PANEL_HEIGHT = 128;

    localparam int CELL_W  = 6;
    localparam int CELL_H  = 8;
    localparam int GLYPH_W = 5;
    localparam int GLYPH_H = 7;

    // Last cursor position at which a whole cell still fits
    localparam logic [7:0] COL_LIMIT = 8'(PANEL_WIDTH - CELL_W);
    localparam logic [7:0] ROW_LIMIT = 8'(PANEL_HEIGHT - CELL_H);

    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    localparam logic [7:0] CMD_COLUMN_WINDOW = 8'h2A;
    localparam logic [7:0] CMD_ROW_WINDOW    = 8'h2B;
    localparam logic [7:0] CMD_MEMORY_WRITE  = 8'h2C;

    localparam logic [1:0] KIND_CMD   = 2'd0;
    localparam logic [1:0] KIND_PARAM = 2'd1;
    localparam logic [1:0] KIND_PIXEL = 2'd2;

    localparam logic CFG_COLUMN_OFFSET = 1'b0;
    localparam logic CFG_ROW_OFFSET    = 1'b1;

    localparam int JOB_QUEUE_DEPTH = 2;

    // One byte per glyph column, bit r is row r
    typedef logic [GLYPH_W-1:0][7:0] glyph_t;

    // Window coordinates already include the panel offsets
    typedef struct packed {
        logic [8:0]  col_start;
        logic [8:0]  col_end;
        logic [8:0]  row_start;
        logic [8:0]  row_end;
        glyph_t      glyph;
        logic [15:0] fore_colour;
        logic [15:0] back_colour;
    } job_t;

    // Packed as {col4, col3, col2, col1, col0}
    function automatic glyph_t font_lookup(input logic [7:0] code);
        glyph_t g;
        unique case (code)
            8'h2E:   g = {8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
            8'h30:   g = {8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E};
            8'h31:   g = {8'h00, 8'h40, 8'h7F, 8'h42, 8'h00};
            8'h32:   g = {8'h46, 8'h49, 8'h51, 8'h61, 8'h42};
            8'h33:   g = {8'h31, 8'h4B, 8'h45, 8'h41, 8'h21};
            8'h34:   g = {8'h10, 8'h7F, 8'h12, 8'h14, 8'h18};
            8'h35:   g = {8'h39, 8'h45, 8'h45, 8'h45, 8'h27};
            8'h36:   g = {8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C};
            8'h37:   g = {8'h03, 8'h05, 8'h09, 8'h71, 8'h01};
            8'h38:   g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
            8'h39:   g = {8'h1E, 8'h29, 8'h49, 8'h49, 8'h06};
            8'h41:   g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
            8'h42:   g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h7F};
            8'h43:   g = {8'h22, 8'h41, 8'h41, 8'h41, 8'h3E};
            8'h44:   g = {8'h1C, 8'h22, 8'h41, 8'h41, 8'h7F};
            8'h45:   g = {8'h41, 8'h49, 8'h49, 8'h49, 8'h7F};
            8'h46:   g = {8'h01, 8'h01, 8'h09, 8'h09, 8'h7F};
            8'h47:   g = {8'h7A, 8'h49, 8'h49, 8'h41, 8'h3E};
            8'h48:   g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
            8'h49:   g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
            8'h4A:   g = {8'h01, 8'h3F, 8'h41, 8'h40, 8'h20};
            8'h4B:   g = {8'h41, 8'h22, 8'h14, 8'h08, 8'h7F};
            8'h4C:   g = {8'h40, 8'h40, 8'h40, 8'h40, 8'h7F};
            8'h4E:   g = {8'h7F, 8'h10, 8'h0C, 8'h02, 8'h7F};
            8'h4F:   g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
            8'h50:   g = {8'h06, 8'h09, 8'h09, 8'h09, 8'h7F};
            8'h52:   g = {8'h46, 8'h29, 8'h19, 8'h09, 8'h7F};
            8'h53:   g = {8'h31, 8'h49, 8'h49, 8'h49, 8'h46};
            8'h54:   g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
            8'h55:   g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
            8'h56:   g = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
            8'h57:   g = {8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F};
            8'h5F:   g = {8'h40, 8'h40, 8'h40, 8'h40, 8'h40};
            default: g = '0;  // space and unknown codes
        endcase
        return g;
    endfunction

endpackage

/* src/text_to_panel_pixel_stream.sv */
// ----------------------------------------------------------------------------
// text_to_panel_pixel_stream: 5x7 font text to panel command/pixel stream
// Renders characters into window commands and RGB565 pixels for a panel.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: drive push with one character and its
//   string_start/origin/colour fields; the beat is taken when full is low.
//   Output side is a queue read port: while empty is low the oldest beat is on
//   item_kind/item_value/last_of_cell; pop takes it.
//   Config: cfg_wr_en with cfg_addr 0 (column offset) or 1 (row offset) and
//   cfg_wdata; write only while the block is idle.
//   A drawn character gives 59 beats: column window (5), row window (5),
//   memory write (1), then 48 pixels, last_of_cell on the final one.
//   Newline, terminator, stopped and off-screen characters give no beats.
//   With the sequencer idle, a taken character passes the job queue, the
//   sequencer's job register and the output register before its first beat.
//   Throughput: one beat per cycle from the output stage while pop stays
//   high, the next cell following with no gap; a two-entry job queue
//   lets the front end take characters while a cell is still being sent.
//   When pop is held low the output stage holds, the sequencer stalls, and
//   full rises once the job queue fills. Reset clears cursor, string state
//   and queues, and loads offsets 2 and 1.
// ----------------------------------------------------------------------------
module text_to_panel_pixel_stream (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        string_start,
    input  logic [7:0]  origin_column,
    input  logic [7:0]  origin_row,
    input  logic [7:0]  char_code,
    input  logic [15:0] fore_colour,
    input  logic [15:0] back_colour,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  item_kind,
    output logic [15:0] item_value,
    output logic        last_of_cell,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata
);
    import ttp_pkg::*;

    job_t front_job;
    job_t queue_job;
    logic job_push;
    logic job_full;
    logic job_valid;
    logic job_pop;

    ttp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .string_start  (string_start),
        .origin_column (origin_column),
        .origin_row    (origin_row),
        .char_code     (char_code),
        .fore_colour   (fore_colour),
        .back_colour   (back_colour),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .job_push      (job_push),
        .job           (front_job),
        .job_full      (job_full)
    );

    ttp_job_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_job  (front_job),
        .q_full  (job_full),
        .q_valid (job_valid),
        .rd_en   (job_pop),
        .rd_job  (queue_job)
    );

    ttp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (job_valid),
        .q_job        (queue_job),
        .q_pop        (job_pop),
        .empty        (empty),
        .pop          (pop),
        .item_kind    (item_kind),
        .item_value   (item_value),
        .last_of_cell (last_of_cell)
    );

endmodule

/* src/ttp_front.sv */
// ----------------------------------------------------------------------------
// ttp_front: character front end
// Accepts characters, tracks cursor and string state, and turns each drawable
// character into a job with window coordinates and glyph for the sequencer.
// ----------------------------------------------------------------------------
module ttp_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic          string_start,
    input  logic [7:0]    origin_column,
    input  logic [7:0]    origin_row,
    input  logic [7:0]    char_code,
    input  logic [15:0]   fore_colour,
    input  logic [15:0]   back_colour,
    input  logic          cfg_wr_en,
    input  logic          cfg_addr,
    input  logic [7:0]    cfg_wdata,
    output logic          job_push,
    output ttp_pkg::job_t job,
    input  logic          job_full
);
    import ttp_pkg::*;

    logic [7:0] column_offset_reg, column_offset_next;
    logic [7:0] row_offset_reg, row_offset_next;
    logic [7:0] cursor_column_reg, cursor_column_next;
    logic [7:0] cursor_row_reg, cursor_row_next;
    logic [7:0] line_start_reg, line_start_next;
    logic       stopped_reg, stopped_next;

    logic       accept;
    logic       draw;
    logic [7:0] eff_col;
    logic [7:0] eff_row;
    logic [7:0] eff_line;
    logic       eff_stop;

    assign full   = job_full;
    assign accept = push && !job_full;

    // A string start takes effect before the same beat's character
    assign eff_col  = string_start ? origin_column : cursor_column_reg;
    assign eff_row  = string_start ? origin_row    : cursor_row_reg;
    assign eff_line = string_start ? origin_column : line_start_reg;
    assign eff_stop = string_start ? 1'b0          : stopped_reg;

    always_comb
    begin
        column_offset_next = column_offset_reg;
        row_offset_next    = row_offset_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_COLUMN_OFFSET: column_offset_next = cfg_wdata;
                CFG_ROW_OFFSET:    row_offset_next    = cfg_wdata;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        cursor_column_next = cursor_column_reg;
        cursor_row_next    = cursor_row_reg;
        line_start_next    = line_start_reg;
        stopped_next       = stopped_reg;
        draw               = 1'b0;
        if (accept)
        begin
            cursor_column_next = eff_col;
            cursor_row_next    = eff_row;
            line_start_next    = eff_line;
            stopped_next       = eff_stop;
            if (!eff_stop)
            begin
                if (char_code == CHAR_NUL)
                begin
                    stopped_next = 1'b1;
                end
                else if (char_code == CHAR_NEWLINE)
                begin
                    cursor_column_next = eff_line;
                    cursor_row_next    = eff_row + 8'(CELL_H);
                end
                else if (eff_col > COL_LIMIT)
                begin
                    stopped_next = 1'b1;
                end
                else
                begin
                    // off-screen rows still move the cursor
                    draw               = (eff_row <= ROW_LIMIT);
                    cursor_column_next = eff_col + 8'(CELL_W);
                end
            end
        end
    end

    assign job_push        = draw;
    assign job.col_start   = {1'b0, eff_col} + {1'b0, column_offset_reg};
    assign job.col_end     = {1'b0, eff_col} + {1'b0, column_offset_reg} + 9'(CELL_W - 1);
    assign job.row_start   = {1'b0, eff_row} + {1'b0, row_offset_reg};
    assign job.row_end     = {1'b0, eff_row} + {1'b0, row_offset_reg} + 9'(CELL_H - 1);
    assign job.glyph       = font_lookup(char_code);
    assign job.fore_colour = fore_colour;
    assign job.back_colour = back_colour;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_offset_reg <= 8'd2;
            row_offset_reg    <= 8'd1;
            cursor_column_reg <= '0;
            cursor_row_reg    <= '0;
            line_start_reg    <= '0;
            stopped_reg       <= 1'b0;
        end
        else
        begin
            column_offset_reg <= column_offset_next;
            row_offset_reg    <= row_offset_next;
            cursor_column_reg <= cursor_column_next;
            cursor_row_reg    <= cursor_row_next;
            line_start_reg    <= line_start_next;
            stopped_reg       <= stopped_next;
        end
    end

endmodule

/* src/ttp_job_queue.sv */
// ----------------------------------------------------------------------------
// ttp_job_queue: short job queue
// Small FIFO of cell jobs between the front end and the beat sequencer.
// ----------------------------------------------------------------------------
module ttp_job_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  ttp_pkg::job_t wr_job,
    output logic          q_full,
    output logic          q_valid,
    input  logic          rd_en,
    output ttp_pkg::job_t rd_job
);
    import ttp_pkg::*;

    localparam int PTR_W = (JOB_QUEUE_DEPTH > 1) ? $clog2(JOB_QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(JOB_QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(JOB_QUEUE_DEPTH - 1);

    job_t             slot_reg [JOB_QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign q_full  = (count_reg == CNT_W'(JOB_QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && q_valid;
    assign rd_job  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* src/ttp_back.sv */
// ----------------------------------------------------------------------------
// ttp_back: beat sequencer
// Plays one cell job out as 11 command/parameter beats and 48 pixel beats
// through a registered output stage.
// ----------------------------------------------------------------------------
module ttp_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  ttp_pkg::job_t q_job,
    output logic          q_pop,
    output logic          empty,
    input  logic          pop,
    output logic [1:0]    item_kind,
    output logic [15:0]   item_value,
    output logic          last_of_cell
);
    import ttp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_HDR  = 3'b010,
        ST_PIX  = 3'b100
    } seq_state_t;

    // header beat positions
    localparam logic [3:0] HDR_COL_CMD = 4'd0;
    localparam logic [3:0] HDR_CS_HI   = 4'd1;
    localparam logic [3:0] HDR_CS_LO   = 4'd2;
    localparam logic [3:0] HDR_CE_HI   = 4'd3;
    localparam logic [3:0] HDR_CE_LO   = 4'd4;
    localparam logic [3:0] HDR_ROW_CMD = 4'd5;
    localparam logic [3:0] HDR_RS_HI   = 4'd6;
    localparam logic [3:0] HDR_RS_LO   = 4'd7;
    localparam logic [3:0] HDR_RE_HI   = 4'd8;
    localparam logic [3:0] HDR_RE_LO   = 4'd9;
    localparam logic [3:0] HDR_MEM_CMD = 4'd10;

    localparam logic [2:0] PIX_COL_LAST = 3'(CELL_W - 1);
    localparam logic [2:0] PIX_ROW_LAST = 3'(CELL_H - 1);

    seq_state_t  state_reg, state_next;
    logic [3:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [2:0]  pix_col_reg, pix_col_next;
    logic [2:0]  pix_row_reg, pix_row_next;
    job_t        job_reg;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_kind_reg, out_kind_next;
    logic [15:0] out_value_reg, out_value_next;
    logic        out_last_reg, out_last_next;

    logic        adv;
    logic        take;
    logic        pix_last;
    logic        glyph_bit;
    logic [1:0]  beat_kind;
    logic [15:0] beat_value;

    assign adv      = !out_valid_reg || pop;
    assign pix_last = (pix_col_reg == PIX_COL_LAST) && (pix_row_reg == PIX_ROW_LAST);

    always_comb
    begin
        glyph_bit = 1'b0;
        if ((pix_col_reg < 3'(GLYPH_W)) && (pix_row_reg < 3'(GLYPH_H)))
        begin
            glyph_bit = job_reg.glyph[pix_col_reg][pix_row_reg];
        end
    end

    always_comb
    begin
        beat_kind  = KIND_PARAM;
        beat_value = '0;
        if (state_reg == ST_PIX)
        begin
            beat_kind  = KIND_PIXEL;
            beat_value = glyph_bit ? job_reg.fore_colour : job_reg.back_colour;
        end
        else
        begin
            unique case (hdr_cnt_reg)
                HDR_COL_CMD:
                begin
                    beat_kind  = KIND_CMD;
                    beat_value = {8'h00, CMD_COLUMN_WINDOW};
                end
                HDR_CS_HI: beat_value = {15'h0000, job_reg.col_start[8]};
                HDR_CS_LO: beat_value = {8'h00, job_reg.col_start[7:0]};
                HDR_CE_HI: beat_value = {15'h0000, job_reg.col_end[8]};
                HDR_CE_LO: beat_value = {8'h00, job_reg.col_end[7:0]};
                HDR_ROW_CMD:
                begin
                    beat_kind  = KIND_CMD;
                    beat_value = {8'h00, CMD_ROW_WINDOW};
                end
                HDR_RS_HI: beat_value = {15'h0000, job_reg.row_start[8]};
                HDR_RS_LO: beat_value = {8'h00, job_reg.row_start[7:0]};
                HDR_RE_HI: beat_value = {15'h0000, job_reg.row_end[8]};
                HDR_RE_LO: beat_value = {8'h00, job_reg.row_end[7:0]};
                HDR_MEM_CMD:
                begin
                    beat_kind  = KIND_CMD;
                    beat_value = {8'h00, CMD_MEMORY_WRITE};
                end
                default:
                begin
                    beat_kind  = KIND_PARAM;
                    beat_value = '0;
                end
            endcase
        end
    end

    // next job loads with no gap after the last pixel of the current one
    assign take  = q_valid && ((state_reg == ST_IDLE) ||
                               ((state_reg == ST_PIX) && pix_last && adv));
    assign q_pop = take;

    always_comb
    begin
        state_next   = state_reg;
        hdr_cnt_next = hdr_cnt_reg;
        pix_col_next = pix_col_reg;
        pix_row_next = pix_row_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next   = ST_HDR;
                    hdr_cnt_next = HDR_COL_CMD;
                end
            end
            ST_HDR:
            begin
                if (adv)
                begin
                    if (hdr_cnt_reg == HDR_MEM_CMD)
                    begin
                        state_next   = ST_PIX;
                        pix_col_next = '0;
                        pix_row_next = '0;
                    end
                    else
                    begin
                        hdr_cnt_next = hdr_cnt_reg + 1'b1;
                    end
                end
            end
            ST_PIX:
            begin
                if (adv)
                begin
                    if (pix_last)
                    begin
                        state_next   = take ? ST_HDR : ST_IDLE;
                        hdr_cnt_next = HDR_COL_CMD;
                    end
                    else if (pix_col_reg == PIX_COL_LAST)
                    begin
                        pix_col_next = '0;
                        pix_row_next = pix_row_reg + 1'b1;
                    end
                    else
                    begin
                        pix_col_next = pix_col_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        if (adv)
        begin
            out_valid_next = (state_reg != ST_IDLE);
            out_kind_next  = beat_kind;
            out_value_next = beat_value;
            out_last_next  = (state_reg == ST_PIX) && pix_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            job_reg <= q_job;
        end
        out_kind_reg  <= out_kind_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hdr_cnt_reg   <= '0;
            pix_col_reg   <= '0;
            pix_row_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            pix_col_reg   <= pix_col_next;
            pix_row_reg   <= pix_row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty        = !out_valid_reg;
    assign item_kind    = out_kind_reg;
    assign item_value   = out_value_reg;
    assign last_of_cell = out_last_reg;

endmodule
